// File: sv/jeo_pkg.sv
package jeo_pkg;

    // Width of a person number and of both configuration registers.
    localparam int ENTRY_W = 11;

    // Default capacity of the circle.
    localparam int CIRCLE_MAX_DEF = 1024;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 1'b1;

    // Bit counter of the remainder unit, one dividend bit per cycle.
    localparam int DIV_IDX_W = $clog2(ENTRY_W);

    typedef struct packed {
        logic busy;
        logic done;
    } jeo_div_stat_t;

endpackage

// File: sv/jeo_req_if.sv
interface jeo_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// File: sv/jeo_res_if.sv
interface jeo_res_if;
    logic                         valid;
    logic                         ready;
    logic [jeo_pkg::ENTRY_W-1:0]  removed_person;
    logic                         last_one;
    logic                         empty_error;

    modport source (output valid, output removed_person, output last_one,
                    output empty_error, input ready);
    modport sink (input valid, input removed_person, input last_one,
                  input empty_error, output ready);
endinterface

// File: sv/jeo_ring.sv
module jeo_ring #(
    parameter int CIRCLE_MAX = jeo_pkg::CIRCLE_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(CIRCLE_MAX+1)-1:0]     wr_addr,
    input  logic [jeo_pkg::ENTRY_W-1:0]         wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(CIRCLE_MAX+1)-1:0]     rd_addr,
    output logic [jeo_pkg::ENTRY_W-1:0]         rd_data
);

    localparam int RING_LEN = CIRCLE_MAX + 1;

    logic [jeo_pkg::ENTRY_W-1:0] mem [RING_LEN];
    logic [jeo_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/jeo_mod_unit.sv
module jeo_mod_unit #(
    parameter int CIRCLE_MAX = jeo_pkg::CIRCLE_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [jeo_pkg::ENTRY_W-1:0]         dividend,
    input  logic [$clog2(CIRCLE_MAX+1)-1:0]     divisor,
    output jeo_pkg::jeo_div_stat_t              stat,
    output logic [$clog2(CIRCLE_MAX+1)-1:0]     remainder
);

    localparam int CW = $clog2(CIRCLE_MAX + 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [jeo_pkg::DIV_IDX_W-1:0]     idx_reg, idx_next;
    logic [jeo_pkg::ENTRY_W-1:0]       dvd_reg, dvd_next;
    logic [CW-1:0]                     rem_reg, rem_next;
    logic [CW:0]                       trial;
    logic [CW:0]                       diff;

    // Restoring remainder: one dividend bit enters per cycle and the divisor
    // is taken off whenever the partial remainder reaches it.
    assign trial = {rem_reg, dvd_reg[jeo_pkg::ENTRY_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = jeo_pkg::DIV_IDX_W'(jeo_pkg::ENTRY_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[jeo_pkg::ENTRY_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[CW-1:0];
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/josephus_elimination_order_core.sv
// Channel | Dir | Fields                                     | Word
// req     | in  | restart                                    | one request
// res     | out | removed_person, last_one, empty_error       | one result
// cfg     | in  | cfg_we, cfg_index, cfg_data                | register write
//
// After acceptance, the count is checked, the bit-serial remainder unit forms
// r = (step_count - 1) mod (people left), and r ring entries rotate from head
// to tail at one entry per cycle before the victim is read; an empty circle
// skips to its result. A restart costs nothing extra, since refilled entries
// are recognized by address, and reset needs no clearing pass. The result is
// held until taken; the next request can be taken in the cycle after.
module josephus_elimination_order_core #(
    parameter int CIRCLE_MAX = jeo_pkg::CIRCLE_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jeo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jeo_pkg::ENTRY_W-1:0]     cfg_data,
    jeo_req_if.sink                         req,
    jeo_res_if.source                       res
);

    localparam int AW = $clog2(CIRCLE_MAX + 1);
    localparam int EW = jeo_pkg::ENTRY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_ROT,
        S_PICK,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   nlat_reg, nlat_next;
    logic [AW-1:0]   wmark_reg, wmark_next;
    logic [AW-1:0]   rot_left_reg, rot_left_next;
    logic            pend_reg, pend_next;
    logic [EW-1:0]   size_reg, size_next;
    logic [EW-1:0]   step_reg, step_next;
    logic [EW-1:0]   person_reg, person_next;
    logic            last_reg, last_next;
    logic            err_reg, err_next;
    logic            fresh_reg, fresh_next;
    logic [AW-1:0]   raddr_reg, raddr_next;

    logic            rd_en;
    logic            wr_en;
    logic [EW-1:0]   mem_rd_data;
    logic [EW-1:0]   rd_value;
    logic [AW-1:0]   n_eff;
    logic            div_start;
    logic [EW-1:0]   div_dividend;
    logic [AW-1:0]   div_rem;
    jeo_pkg::jeo_div_stat_t div_stat;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(CIRCLE_MAX))
        begin
            q = '0;
        end
        else
        begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    jeo_ring #(
        .CIRCLE_MAX (CIRCLE_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (rd_value),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    jeo_mod_unit #(
        .CIRCLE_MAX (CIRCLE_MAX)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cnt_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // An entry below the refill size that the tail has not yet overwritten
    // since the last restart is read as its own address plus one.
    assign rd_value = fresh_reg ? EW'(32'(raddr_reg) + 32'd1) : mem_rd_data;

    assign n_eff = (32'(size_reg) > CIRCLE_MAX) ? AW'(CIRCLE_MAX) : AW'(size_reg);

    assign div_dividend = (step_reg == '0) ? '0 : step_reg - EW'(1);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        nlat_next     = nlat_reg;
        wmark_next    = wmark_reg;
        rot_left_next = rot_left_reg;
        pend_next     = pend_reg;
        size_next     = size_reg;
        step_next     = step_reg;
        person_next   = person_reg;
        last_next     = last_reg;
        err_next      = err_reg;
        fresh_next    = fresh_reg;
        raddr_next    = raddr_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        div_start     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                jeo_pkg::CFG_CIRCLE_SIZE: size_next = cfg_data;
                jeo_pkg::CFG_STEP_COUNT:  step_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.restart)
                    begin
                        head_next  = '0;
                        tail_next  = n_eff;
                        cnt_next   = n_eff;
                        nlat_next  = n_eff;
                        wmark_next = '0;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cnt_reg == '0)
                begin
                    person_next = '0;
                    last_next   = 1'b0;
                    err_next    = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (div_stat.done)
                begin
                    rot_left_next = div_rem;
                    pend_next     = 1'b0;
                    state_next    = S_ROT;
                end
            end
            S_ROT:
            begin
                // The word read last cycle goes to the tail while the next
                // head entry is read; the final read is the victim.
                if (pend_reg)
                begin
                    wr_en     = 1'b1;
                    tail_next = ring_next(tail_reg);
                    if ((tail_reg == wmark_reg) && (wmark_reg < nlat_reg))
                    begin
                        wmark_next = wmark_reg + 1'b1;
                    end
                end
                rd_en      = 1'b1;
                raddr_next = head_reg;
                fresh_next = (head_reg < nlat_reg) && (head_reg >= wmark_reg);
                head_next  = ring_next(head_reg);
                if (rot_left_reg != '0)
                begin
                    rot_left_next = rot_left_reg - 1'b1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                person_next = rd_value;
                last_next   = (cnt_reg == AW'(1));
                err_next    = 1'b0;
                cnt_next    = cnt_reg - 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            nlat_reg     <= '0;
            wmark_reg    <= '0;
            rot_left_reg <= '0;
            pend_reg     <= 1'b0;
            size_reg     <= EW'(1);
            step_reg     <= EW'(1);
            last_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            nlat_reg     <= nlat_next;
            wmark_reg    <= wmark_next;
            rot_left_reg <= rot_left_next;
            pend_reg     <= pend_next;
            size_reg     <= size_next;
            step_reg     <= step_next;
            last_reg     <= last_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        person_reg <= person_next;
        fresh_reg  <= fresh_next;
        raddr_reg  <= raddr_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign res.valid          = (state_reg == S_OUT);
    assign res.removed_person = person_reg;
    assign res.last_one       = last_reg;
    assign res.empty_error    = err_reg;

    // The number of people never exceeds the capacity of the circle.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= CIRCLE_MAX)
    else $error("circle count above capacity");

    // An empty-circle result carries no person and no last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.empty_error |-> (res.removed_person == '0) && !res.last_one)
    else $error("empty error with a person");

    // The last removal leaves the circle empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last_one |-> (cnt_reg == '0) && (head_reg == tail_reg))
    else $error("last flag with people left");

    // A new request is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && res.valid))
    else $error("request accepted while result pending");

endmodule

// File: verif/elimination_order_check.sv
module elimination_order_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jeo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jeo_pkg::ENTRY_W-1:0]     cfg_data,
    jeo_req_if                              req,
    jeo_res_if                              res,
    output int unsigned                     pending,
    output int unsigned                     mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING_LEN = jeo_pkg::CIRCLE_MAX_DEF + 1;
    localparam int EW = jeo_pkg::ENTRY_W;

    typedef struct packed {
        logic [EW-1:0] person;
        logic          last_one;
        logic          empty_error;
    } removal_t;

    // Shadow of the circle, kept in the same circular layout as the block's ring.
    logic [EW-1:0] ring_image [RING_LEN];
    int unsigned   head_idx;
    int unsigned   tail_idx;
    logic [EW-1:0] people_cfg;
    logic [EW-1:0] step_cfg;
    removal_t      awaited_removals [$];
    removal_t      want;

    function automatic int unsigned ring_advance(input int unsigned p);
        return (p + 1 == RING_LEN) ? 0 : p + 1;
    endfunction

    function automatic removal_t predict_removal(input logic restart);
        int unsigned   fill;
        int unsigned   present;
        int unsigned   turns;
        logic [EW-1:0] moved;
        removal_t      outcome;
        if (restart)
        begin
            fill = (people_cfg > jeo_pkg::CIRCLE_MAX_DEF) ? jeo_pkg::CIRCLE_MAX_DEF
                                                          : people_cfg;
            for (int unsigned i = 0; i < fill; i++)
                ring_image[i] = EW'(i + 1);
            head_idx = 0;
            tail_idx = fill;
        end
        present = (tail_idx >= head_idx) ? tail_idx - head_idx
                                         : tail_idx + RING_LEN - head_idx;
        if (present == 0)
        begin
            outcome = '{person: '0, last_one: 1'b0, empty_error: 1'b1};
            return outcome;
        end
        // A step of zero behaves like a step of one; long steps wrap around the circle.
        turns = (step_cfg == 0) ? 0 : (step_cfg - 1) % present;
        repeat (turns)
        begin
            moved = ring_image[head_idx];
            head_idx = ring_advance(head_idx);
            ring_image[tail_idx] = moved;
            tail_idx = ring_advance(tail_idx);
        end
        outcome.person = ring_image[head_idx];
        head_idx = ring_advance(head_idx);
        outcome.last_one = (head_idx == tail_idx);
        outcome.empty_error = 1'b0;
        return outcome;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        $display("[%0t] removal mismatch: %s: got %0d, expected %0d",
                 $time, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx = 0;
            tail_idx = 0;
            people_cfg = EW'(1);
            step_cfg = EW'(1);
            awaited_removals.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    jeo_pkg::CFG_CIRCLE_SIZE: people_cfg = cfg_data;
                    jeo_pkg::CFG_STEP_COUNT:  step_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (awaited_removals.size() == 0)
                begin
                    report_mismatch("result word with no request waiting",
                                    32'(res.removed_person), 0);
                end
                else
                begin
                    want = awaited_removals.pop_front();
                    if (res.removed_person !== want.person)
                        report_mismatch("removed_person", 32'(res.removed_person),
                                        32'(want.person));
                    if (res.last_one !== want.last_one)
                        report_mismatch("last_one", 32'(res.last_one),
                                        32'(want.last_one));
                    if (res.empty_error !== want.empty_error)
                        report_mismatch("empty_error", 32'(res.empty_error),
                                        32'(want.empty_error));
                end
            end
            if (req.valid && req.ready)
                awaited_removals.push_back(predict_removal(req.restart));
        end
        pending = awaited_removals.size();
    end

endmodule

// File: verif/tb_josephus_elimination_order_core.sv
module tb_josephus_elimination_order_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REQUEST_TARGET = 1450;
    // Far above any correct run: even every request at the longest rotation fits.
    localparam int unsigned CYCLE_LIMIT    = 8_000_000;
    localparam int unsigned HOLD_OFF_LEN   = 400;
    localparam int          EW             = jeo_pkg::ENTRY_W;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [jeo_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [EW-1:0]                 cfg_data;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned requests_sent;
    bit          steady_sender;
    bit          stall_requested;

    jeo_req_if req_ch ();
    jeo_res_if res_ch ();

    josephus_elimination_order_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    elimination_order_check order_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .res        (res_ch),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic send_request(input bit restart_bit);
        int unsigned gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.restart <= restart_bit;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        requests_sent++;
    endtask

    // Sampled at the falling edge so the checker has seen the last accepted word.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic reconfigure(input logic [EW-1:0] people,
                               input logic [EW-1:0] stride);
        drain_results();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= jeo_pkg::CFG_CIRCLE_SIZE;
        cfg_data <= people;
        @(posedge clk);
        cfg_index <= jeo_pkg::CFG_STEP_COUNT;
        cfg_data <= stride;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, long ready stretches, and one long hold-off on request.
    initial
    begin
        int unsigned gap;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_requested)
            begin
                stall_requested = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                begin
                    res_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [EW-1:0] people;
        logic [EW-1:0] stride;
        int unsigned   filled;
        int unsigned   run_len;
        int unsigned   roll;
        int unsigned   phase;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = jeo_pkg::CFG_CIRCLE_SIZE;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.restart = 1'b0;
        requests_sent = 0;
        steady_sender = 1'b0;
        stall_requested = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset circle is empty; the default size gives a circle of one.
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // A zero size leaves the circle empty even on restart.
        reconfigure(11'd0, 11'd5);
        send_request(1'b1);

        // A zero step removes people in order, then the circle runs dry.
        reconfigure(11'd5, 11'd0);
        send_request(1'b1);
        repeat (5) send_request(1'b0);

        reconfigure(11'd7, 11'd3);
        send_request(1'b1);
        repeat (6) send_request(1'b0);

        // All ones in both registers: size saturates, step wraps the full circle.
        reconfigure(11'h7FF, 11'h7FF);
        send_request(1'b1);
        send_request(1'b0);

        // Step much longer than the circle.
        reconfigure(11'd3, 11'd1000);
        send_request(1'b1);
        repeat (2) send_request(1'b0);

        phase = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                people = 11'd0;
            else if (roll < 10)
                people = 11'd1;
            else if (roll < 75)
                people = 11'($urandom_range(2, 24));
            else if (roll < 85)
                people = 11'($urandom_range(25, 120));
            else if (roll < 93)
                people = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom_range(1025, 2047));
            else
                people = 11'($urandom_range(0, 2047));

            roll = $urandom_range(0, 99);
            if (roll < 5)
                stride = 11'd0;
            else if (roll < 10)
                stride = 11'd1;
            else if (roll < 70)
                stride = 11'($urandom_range(2, 12));
            else if (roll < 85)
                stride = 11'($urandom_range(13, 100));
            else if (roll < 95)
                stride = 11'($urandom_range(101, 1024));
            else
                stride = 11'($urandom_range(1025, 2047));

            if (phase == 2)
            begin
                people = 11'd60;
                stride = 11'd4;
            end
            reconfigure(people, stride);
            steady_sender = (phase == 2) || ($urandom_range(0, 4) == 0);
            // The result side freezes while requests keep coming, so the block backs up.
            if (phase == 2)
            begin
                stall_requested = 1'b1;
                wait (!stall_requested);
            end

            filled = (people > jeo_pkg::CIRCLE_MAX_DEF) ? jeo_pkg::CIRCLE_MAX_DEF : people;
            repeat ($urandom_range(1, 3))
            begin
                if (phase != 2 && $urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 4)) send_request(1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_request(1'b1);
                    if (filled <= 60)
                        run_len = (filled == 0) ? 0 : filled - 1;
                    else
                        run_len = $urandom_range(3, 40);
                    // Sometimes a sequence is cut short by the next restart.
                    if (phase != 2 && run_len > 0 && $urandom_range(0, 4) == 0)
                        run_len = $urandom_range(0, run_len - 1);
                    repeat (run_len) send_request(1'b0);
                    if (filled <= 60 && $urandom_range(0, 2) == 0)
                        send_request(1'b0);
                end
            end
            phase++;
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
sv/jeo_pkg.sv
sv/jeo_req_if.sv
sv/jeo_res_if.sv
sv/jeo_ring.sv
sv/jeo_mod_unit.sv
sv/josephus_elimination_order_core.sv
verif/elimination_order_check.sv
verif/tb_josephus_elimination_order_core.sv
